// File: rtl/core/pairwise_ld_r2_dprime_assert.svh
// Assertion macros for the pairwise LD block.
// Included by pairwise_ld_r2_dprime.sv, the one RTL file with concurrent checks; no other dependencies.
`ifndef PAIRWISE_LD_R2_DPRIME_ASSERT_SVH
`define PAIRWISE_LD_R2_DPRIME_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define PLDR_ASSERT(label, clk_s, rstn_s, prop) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
		else $error("pairwise_ld_r2_dprime: assertion failed");

// condition must never be seen outside reset
`define PLDR_ASSERT_NEVER(label, clk_s, rstn_s, cond) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
		else $error("pairwise_ld_r2_dprime: forbidden condition seen");

`else

`define PLDR_ASSERT(label, clk_s, rstn_s, prop)
`define PLDR_ASSERT_NEVER(label, clk_s, rstn_s, cond)

`endif

`endif

// File: rtl/core/pldr_pkg.sv
// Shared constants and types for the pairwise LD (r squared / D prime) block.
// No dependencies.
package pldr_pkg;

	localparam int FRAC_W   = 16;
	localparam int R2_W     = 17;
	localparam int DP_W     = 24;
	localparam int NS_OUT_W = 17;
	localparam int QUO_W    = 24;

	localparam logic [QUO_W-1:0] R2_LIMIT     = QUO_W'(1 << FRAC_W);
	localparam logic [QUO_W-1:0] DP_POS_LIMIT = QUO_W'((1 << (DP_W - 1)) - 1);
	localparam logic [QUO_W-1:0] DP_NEG_LIMIT = QUO_W'(1 << (DP_W - 1));
	localparam logic signed [DP_W-1:0] DP_INVALID = DP_W'(-(1 << FRAC_W));

	typedef enum logic {
		CFG_FIRST_ON_X  = 1'b0,
		CFG_SECOND_ON_X = 1'b1
	} cfg_idx_t;

	typedef logic [1:0] allele_t;

endpackage

// File: rtl/core/pairwise_ld_r2_dprime.sv
// Pairwise linkage disequilibrium core: sample accumulation and r^2 / D' evaluation.
// Depends on pldr_pkg and pairwise_ld_r2_dprime_assert.svh.
//
// channel  | dir | signals                                          | handshake
// config   | in  | cfg_index, cfg_data                              | cfg_valid & cfg_ready
// sample   | in  | founder, male, first_*, second_*, last           | start & !busy
// result   | out | r_squared(_valid), d_prime(_valid), used_samples | done, one cycle
//
// a sample without last is taken while idle and leaves busy low; the next one may follow directly
// a sample with last holds busy while the single shared adder runs the shift-add
//   multiplies and the restoring divides one bit per cycle
// done rises on the edge that drops busy; the receiver cannot stall it
// reset clears the sums and both X flags; no clearing pass is needed
`include "pairwise_ld_r2_dprime_assert.svh"

module pairwise_ld_r2_dprime #(
	parameter int MAX_SAMPLES = 65536
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  pldr_pkg::cfg_idx_t               cfg_index,
	input  logic                             cfg_data,
	input  logic                             start,
	output logic                             busy,
	input  logic                             founder,
	input  logic                             male,
	input  logic                             first_bit_one,
	input  logic                             first_bit_two,
	input  logic                             first_missing,
	input  logic                             second_bit_one,
	input  logic                             second_bit_two,
	input  logic                             second_missing,
	input  logic                             last,
	output logic                             done,
	output logic [pldr_pkg::R2_W-1:0]        r_squared,
	output logic                             r_squared_valid,
	output logic signed [pldr_pkg::DP_W-1:0] d_prime,
	output logic                             d_prime_valid,
	output logic [pldr_pkg::NS_OUT_W-1:0]    used_samples
);
	import pldr_pkg::*;

	localparam int NW   = $clog2(MAX_SAMPLES + 1);
	localparam int SW   = NW + 1;
	localparam int QW   = NW + 2;
	localparam int PW   = 2 * NW + 2;
	localparam int DW   = PW + 1;
	localparam int WW   = 2 * PW;
	localparam int NUMW = WW + FRAC_W;
	localparam int AW   = WW + 2;
	localparam int CW   = $clog2(NUMW + 1);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_M_NSXY, ST_M_SXSY, ST_S_DN,
		ST_M_NSXX, ST_M_SXSX, ST_S_V1,
		ST_M_NSYY, ST_M_SYSY, ST_S_V2,
		ST_M_NSY,  ST_S_DM1,  ST_M_NSX, ST_S_DM2,
		ST_S_MIN,  ST_S_ABSDN, ST_S_ABSDM,
		ST_M_VV,   ST_M_DN2,
		ST_D_R2,   ST_D_DP
	} step_t;

	function automatic allele_t allele_count(input logic b1, input logic b2, input logic hap);
		allele_t c;
		if (b1) begin
			c = 2'd0;
		end else if (hap || b2) begin
			c = 2'd1;
		end else begin
			c = 2'd2;
		end
		return c;
	endfunction

	step_t                 step_q, step_nx;
	logic                  first_on_x_q, second_on_x_q;
	logic [NW-1:0]         n_q;
	logic [SW-1:0]         sx_q, sy_q;
	logic [QW-1:0]         sxx_q, syy_q, sxy_q;
	logic [WW-1:0]         acc_q, mcand_q, tmp_q;
	logic [NUMW-1:0]       mplier_q;
	logic [PW-1:0]         p2_q;
	logic signed [DW-1:0]  dn_q, v1_q, v2_q, dm1_q, dmax_q;
	logic                  dn_neg_q, dm_neg_q;
	logic [CW-1:0]         cnt_q;
	logic [QUO_W-1:0]      q_q;
	logic                  ovf_q;
	logic [R2_W-1:0]       r2_q;

	// sample intake
	logic                  p_miss, q_miss, take;
	allele_t               x_cnt, y_cnt;
	logic [2:0]            x_sq, y_sq, xy;

	// sequencer decode and shared adder
	logic                  is_mul, is_div;
	logic [CW-1:0]         iter_lim;
	logic [WW-1:0]         ld_a;
	logic [NUMW-1:0]       ld_b;
	logic [AW-1:0]         alu_a, alu_b, alu_sum;
	logic                  alu_sub;
	logic [WW:0]           rem_sh;
	logic [WW-1:0]         mul_acc;
	logic                  div_ge;
	logic [QUO_W-1:0]      q_nx, dp_lim, dp_mag, dp_val;
	logic                  ovf_nx, dp_neg, r2_ok, dp_ok;

	assign cfg_ready = 1'b1;
	assign busy      = (step_q != ST_IDLE);

	always_comb begin
		p_miss = first_bit_one && first_bit_two && first_missing;
		q_miss = second_bit_one && second_bit_two && second_missing;
		take   = founder && !p_miss && !q_miss && (n_q < NW'(MAX_SAMPLES));
		x_cnt  = allele_count(first_bit_one, first_bit_two, first_on_x_q && male);
		y_cnt  = allele_count(second_bit_one, second_bit_two, second_on_x_q && male);
		// squares of 0, 1, 2
		x_sq   = {x_cnt[1], 1'b0, x_cnt[0]};
		y_sq   = {y_cnt[1], 1'b0, y_cnt[0]};
		xy     = 3'(x_cnt) * 3'(y_cnt);
	end

	always_comb begin
		case (step_q)
			ST_M_NSXY:  step_nx = ST_M_SXSY;
			ST_M_SXSY:  step_nx = ST_S_DN;
			ST_S_DN:    step_nx = ST_M_NSXX;
			ST_M_NSXX:  step_nx = ST_M_SXSX;
			ST_M_SXSX:  step_nx = ST_S_V1;
			ST_S_V1:    step_nx = ST_M_NSYY;
			ST_M_NSYY:  step_nx = ST_M_SYSY;
			ST_M_SYSY:  step_nx = ST_S_V2;
			ST_S_V2:    step_nx = ST_M_NSY;
			ST_M_NSY:   step_nx = ST_S_DM1;
			ST_S_DM1:   step_nx = ST_M_NSX;
			ST_M_NSX:   step_nx = ST_S_DM2;
			ST_S_DM2:   step_nx = ST_S_MIN;
			ST_S_MIN:   step_nx = ST_S_ABSDN;
			ST_S_ABSDN: step_nx = ST_S_ABSDM;
			ST_S_ABSDM: step_nx = ST_M_VV;
			ST_M_VV:    step_nx = ST_M_DN2;
			ST_M_DN2:   step_nx = ST_D_R2;
			ST_D_R2:    step_nx = ST_D_DP;
			default:    step_nx = ST_IDLE;
		endcase
	end

	// operands loaded at the start of each multiply or divide
	always_comb begin
		ld_a     = '0;
		ld_b     = '0;
		iter_lim = '0;
		is_mul   = 1'b0;
		is_div   = 1'b0;
		case (step_q)
			ST_M_NSXY: begin
				ld_a = WW'(n_q);  ld_b = NUMW'(sxy_q); iter_lim = CW'(QW); is_mul = 1'b1;
			end
			ST_M_SXSY: begin
				ld_a = WW'(sx_q); ld_b = NUMW'(sy_q);  iter_lim = CW'(QW); is_mul = 1'b1;
			end
			ST_M_NSXX: begin
				ld_a = WW'(n_q);  ld_b = NUMW'(sxx_q); iter_lim = CW'(QW); is_mul = 1'b1;
			end
			ST_M_SXSX: begin
				ld_a = WW'(sx_q); ld_b = NUMW'(sx_q);  iter_lim = CW'(QW); is_mul = 1'b1;
			end
			ST_M_NSYY: begin
				ld_a = WW'(n_q);  ld_b = NUMW'(syy_q); iter_lim = CW'(QW); is_mul = 1'b1;
			end
			ST_M_SYSY: begin
				ld_a = WW'(sy_q); ld_b = NUMW'(sy_q);  iter_lim = CW'(QW); is_mul = 1'b1;
			end
			ST_M_NSY: begin
				ld_a = WW'(n_q);  ld_b = NUMW'(sy_q);  iter_lim = CW'(QW); is_mul = 1'b1;
			end
			ST_M_NSX: begin
				ld_a = WW'(n_q);  ld_b = NUMW'(sx_q);  iter_lim = CW'(QW); is_mul = 1'b1;
			end
			ST_M_VV: begin
				ld_a     = WW'(v1_q[PW-1:0]);
				ld_b     = NUMW'(v2_q[PW-1:0]);
				iter_lim = CW'(PW);
				is_mul   = 1'b1;
			end
			ST_M_DN2: begin
				ld_a     = WW'(dn_q[PW-1:0]);
				ld_b     = NUMW'(dn_q[PW-1:0]);
				iter_lim = CW'(PW);
				is_mul   = 1'b1;
			end
			ST_D_R2: begin
				// dn^2 scaled by 2^16 over v1*v2
				ld_a     = tmp_q;
				ld_b     = {acc_q, {FRAC_W{1'b0}}};
				iter_lim = CW'(NUMW);
				is_div   = 1'b1;
			end
			ST_D_DP: begin
				ld_a     = WW'(dmax_q[PW-1:0]);
				ld_b     = NUMW'({dn_q[PW-1:0], {FRAC_W{1'b0}}});
				iter_lim = CW'(NUMW);
				is_div   = 1'b1;
			end
			default: ;
		endcase
	end

	// the one adder shared by every step
	always_comb begin
		rem_sh  = {acc_q, mplier_q[NUMW-1]};
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		if (is_mul) begin
			alu_a = AW'(acc_q);
			alu_b = AW'(mcand_q);
		end else if (is_div) begin
			alu_a   = AW'(rem_sh);
			alu_b   = AW'(mcand_q);
			alu_sub = 1'b1;
		end else begin
			case (step_q)
				ST_S_DN, ST_S_DM1, ST_S_DM2: begin
					alu_a = AW'(tmp_q); alu_b = AW'(p2_q); alu_sub = 1'b1;
				end
				ST_S_V1, ST_S_V2: begin
					alu_a = AW'(tmp_q); alu_b = AW'(acc_q); alu_sub = 1'b1;
				end
				ST_S_MIN: begin
					alu_a = AW'(dm1_q); alu_b = AW'(dmax_q); alu_sub = 1'b1;
				end
				ST_S_ABSDN: begin
					alu_b = AW'(dn_q); alu_sub = 1'b1;
				end
				ST_S_ABSDM: begin
					alu_b = AW'(dmax_q); alu_sub = 1'b1;
				end
				default: ;
			endcase
		end
		alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);

		mul_acc = mplier_q[0] ? alu_sum[WW-1:0] : acc_q;
		div_ge  = !alu_sum[AW-1];
		q_nx    = {q_q[QUO_W-2:0], div_ge};
		ovf_nx  = ovf_q | q_q[QUO_W-1];

		dp_neg  = dn_neg_q ^ dm_neg_q;
		dp_lim  = dp_neg ? DP_NEG_LIMIT : DP_POS_LIMIT;
		dp_mag  = (ovf_nx || (q_nx > dp_lim)) ? dp_lim : q_nx;
		dp_val  = dp_neg ? (QUO_W'(0) - dp_mag) : dp_mag;
		r2_ok   = (n_q != '0) && !v1_q[DW-1] && (v1_q != '0) && !v2_q[DW-1] && (v2_q != '0);
		dp_ok   = (dmax_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q          <= ST_IDLE;
			first_on_x_q    <= 1'b0;
			second_on_x_q   <= 1'b0;
			n_q             <= '0;
			sx_q            <= '0;
			sy_q            <= '0;
			sxx_q           <= '0;
			syy_q           <= '0;
			sxy_q           <= '0;
			acc_q           <= '0;
			mcand_q         <= '0;
			mplier_q        <= '0;
			tmp_q           <= '0;
			p2_q            <= '0;
			dn_q            <= '0;
			v1_q            <= '0;
			v2_q            <= '0;
			dm1_q           <= '0;
			dmax_q          <= '0;
			dn_neg_q        <= 1'b0;
			dm_neg_q        <= 1'b0;
			cnt_q           <= '0;
			q_q             <= '0;
			ovf_q           <= 1'b0;
			r2_q            <= '0;
			done            <= 1'b0;
			r_squared       <= '0;
			r_squared_valid <= 1'b0;
			d_prime         <= '0;
			d_prime_valid   <= 1'b0;
			used_samples    <= '0;
		end else begin
			// result word leaves with the last quotient bit of D'
			done <= (step_q == ST_D_DP) && (cnt_q == CW'(NUMW));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FIRST_ON_X:  first_on_x_q  <= cfg_data;
					CFG_SECOND_ON_X: second_on_x_q <= cfg_data;
					default: ;
				endcase
			end
			case (step_q)
				ST_IDLE: begin
					if (start) begin
						if (take) begin
							n_q   <= n_q + NW'(1);
							sx_q  <= sx_q + SW'(x_cnt);
							sy_q  <= sy_q + SW'(y_cnt);
							sxx_q <= sxx_q + QW'(x_sq);
							syy_q <= syy_q + QW'(y_sq);
							sxy_q <= sxy_q + QW'(xy);
						end
						if (last) begin
							step_q <= ST_M_NSXY;
							cnt_q  <= '0;
						end
					end
				end
				ST_S_DN: begin
					dn_q     <= alu_sum[DW-1:0];
					dn_neg_q <= alu_sum[DW-1];
					step_q   <= step_nx;
				end
				ST_S_V1: begin
					v1_q   <= alu_sum[DW-1:0];
					step_q <= step_nx;
				end
				ST_S_V2: begin
					v2_q   <= alu_sum[DW-1:0];
					step_q <= step_nx;
				end
				ST_S_DM1: begin
					dm1_q  <= alu_sum[DW-1:0];
					step_q <= step_nx;
				end
				ST_S_DM2: begin
					dmax_q <= alu_sum[DW-1:0];
					step_q <= step_nx;
				end
				ST_S_MIN: begin
					// dm1 - dm2 negative: dm1 is the smaller one
					if (alu_sum[AW-1]) begin
						dmax_q <= dm1_q;
					end
					step_q <= step_nx;
				end
				ST_S_ABSDN: begin
					if (dn_q[DW-1]) begin
						dn_q <= alu_sum[DW-1:0];
					end
					step_q <= step_nx;
				end
				ST_S_ABSDM: begin
					dm_neg_q <= dmax_q[DW-1];
					if (dmax_q[DW-1]) begin
						dmax_q <= alu_sum[DW-1:0];
					end
					step_q <= step_nx;
				end
				ST_M_NSXY, ST_M_SXSY, ST_M_NSXX, ST_M_SXSX, ST_M_NSYY, ST_M_SYSY,
				ST_M_NSY, ST_M_NSX, ST_M_VV, ST_M_DN2: begin
					if (cnt_q == '0) begin
						acc_q    <= '0;
						mcand_q  <= ld_a;
						mplier_q <= ld_b;
						cnt_q    <= CW'(1);
					end else begin
						// shift-add, one multiplier bit per cycle
						acc_q    <= mul_acc;
						mcand_q  <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
						if (cnt_q == iter_lim) begin
							cnt_q  <= '0;
							step_q <= step_nx;
							case (step_q)
								ST_M_NSXY, ST_M_NSXX, ST_M_NSYY, ST_M_NSY, ST_M_NSX,
								ST_M_VV: tmp_q <= mul_acc;
								ST_M_SXSY: p2_q <= mul_acc[PW-1:0];
								default: ;
							endcase
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				ST_D_R2, ST_D_DP: begin
					if (cnt_q == '0) begin
						acc_q    <= '0;
						mcand_q  <= ld_a;
						mplier_q <= ld_b;
						q_q      <= '0;
						ovf_q    <= 1'b0;
						cnt_q    <= CW'(1);
					end else begin
						// restoring divide, one quotient bit per cycle
						acc_q    <= div_ge ? alu_sum[WW-1:0] : rem_sh[WW-1:0];
						mplier_q <= mplier_q << 1;
						q_q      <= q_nx;
						ovf_q    <= ovf_nx;
						if (cnt_q == iter_lim) begin
							cnt_q  <= '0;
							step_q <= step_nx;
							if (step_q == ST_D_R2) begin
								r2_q <= (ovf_nx || (q_nx > R2_LIMIT)) ? R2_W'(R2_LIMIT)
								                                      : R2_W'(q_nx);
							end else begin
								r_squared       <= r2_ok ? r2_q : '0;
								r_squared_valid <= r2_ok;
								d_prime         <= dp_ok ? DP_W'(dp_val) : DP_INVALID;
								d_prime_valid   <= dp_ok;
								used_samples    <= NS_OUT_W'(n_q);
								n_q             <= '0;
								sx_q            <= '0;
								sy_q            <= '0;
								sxx_q           <= '0;
								syy_q           <= '0;
								sxy_q           <= '0;
							end
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				default: step_q <= ST_IDLE;
			endcase
		end
	end

	`PLDR_ASSERT(a_done_ends_busy, clk, arst_n, done |-> !busy)
	`PLDR_ASSERT(a_done_after_work, clk, arst_n, done |-> $past(busy))
	`PLDR_ASSERT(a_busy_from_last, clk, arst_n, $rose(busy) |-> $past(start && last))
	`PLDR_ASSERT(a_dp_invalid_code, clk, arst_n, (done && !d_prime_valid) |-> (d_prime == DP_INVALID))
	`PLDR_ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > CW'(NUMW))

endmodule

// File: dv/ld_pair_checker.sv
// Checker for pairwise_ld_r2_dprime: watches the config, sample and result channels.
// Predicts each result from its own copy of the sums and flags; depends on pldr_pkg.
module ld_pair_checker #(
	parameter int MAX_N = 65536
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  pldr_pkg::cfg_idx_t               cfg_index,
	input  logic                             cfg_data,
	input  logic                             start,
	input  logic                             busy,
	input  logic                             founder,
	input  logic                             male,
	input  logic                             first_bit_one,
	input  logic                             first_bit_two,
	input  logic                             first_missing,
	input  logic                             second_bit_one,
	input  logic                             second_bit_two,
	input  logic                             second_missing,
	input  logic                             last,
	input  logic                             done,
	input  logic [pldr_pkg::R2_W-1:0]        r_squared,
	input  logic                             r_squared_valid,
	input  logic signed [pldr_pkg::DP_W-1:0] d_prime,
	input  logic                             d_prime_valid,
	input  logic [pldr_pkg::NS_OUT_W-1:0]    used_samples,
	output int                               fail_count,
	output int                               ld_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import pldr_pkg::*;

	typedef struct {
		logic [R2_W-1:0]        r2;
		logic                   r2_ok;
		logic [DP_W-1:0]        dp;
		logic                   dp_ok;
		logic [NS_OUT_W-1:0]    n_used;
	} ld_stats_t;

	ld_stats_t ld_expected[$];

	logic   x_first, x_second;
	longint n_acc, sum_x, sum_y, sum_xx, sum_yy, sum_xy;

	function automatic longint minor_alleles(logic b1, logic b2, logic haploid);
		if (b1)
			return 0;
		if (haploid)
			return 1;
		return b2 ? 1 : 2;
	endfunction

	function automatic logic [127:0] magnitude(longint v);
		return (v < 0) ? 128'(-v) : 128'(v);
	endfunction

	function automatic ld_stats_t ld_from_sums(longint n, longint sx, longint sy,
			longint sxx, longint syy, longint sxy);
		ld_stats_t    res;
		longint       dn, v1, v2, dm1, dm2, dmax;
		logic [127:0] num, den, quo, lim;
		logic         neg;
		res.r2 = '0;
		res.r2_ok = 1'b0;
		res.dp = DP_INVALID;
		res.dp_ok = 1'b0;
		res.n_used = n[NS_OUT_W-1:0];
		dn = n * sxy - sx * sy;
		v1 = n * sxx - sx * sx;
		v2 = n * syy - sy * sy;
		if (n != 0 && v1 > 0 && v2 > 0) begin
			num = magnitude(dn) * magnitude(dn);
			num = num << FRAC_W;
			den = magnitude(v1) * magnitude(v2);
			quo = num / den;
			if (quo > 128'(R2_LIMIT))
				quo = 128'(R2_LIMIT);
			res.r2 = quo[R2_W-1:0];
			res.r2_ok = 1'b1;
		end
		dm1 = (n - sx) * sy;
		dm2 = sx * (n - sy);
		dmax = (dm1 < dm2) ? dm1 : dm2;
		if (dmax != 0) begin
			neg = (dn < 0) != (dmax < 0);
			num = magnitude(dn) << FRAC_W;
			quo = num / magnitude(dmax);
			lim = neg ? 128'(DP_NEG_LIMIT) : 128'(DP_POS_LIMIT);
			if (quo > lim)
				quo = lim;
			res.dp = neg ? -quo[DP_W-1:0] : quo[DP_W-1:0];
			res.dp_ok = 1'b1;
		end
		return res;
	endfunction

	task automatic clear_sums();
		n_acc = 0;
		sum_x = 0;
		sum_y = 0;
		sum_xx = 0;
		sum_yy = 0;
		sum_xy = 0;
	endtask

	task automatic compare_result();
		ld_stats_t want;
		if (ld_expected.size() == 0) begin
			$error("result word with no prediction waiting");
			fail_count++;
			return;
		end
		want = ld_expected.pop_front();
		if (r_squared !== want.r2) begin
			$error("r_squared: expected %0d, got %0d", want.r2, r_squared);
			fail_count++;
		end
		if (r_squared_valid !== want.r2_ok) begin
			$error("r_squared_valid: expected %0d, got %0d", want.r2_ok, r_squared_valid);
			fail_count++;
		end
		if (d_prime !== want.dp) begin
			$error("d_prime: expected %0d, got %0d", $signed(want.dp), d_prime);
			fail_count++;
		end
		if (d_prime_valid !== want.dp_ok) begin
			$error("d_prime_valid: expected %0d, got %0d", want.dp_ok, d_prime_valid);
			fail_count++;
		end
		if (used_samples !== want.n_used) begin
			$error("used_samples: expected %0d, got %0d", want.n_used, used_samples);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		ld_pending = 0;
		x_first = 1'b0;
		x_second = 1'b0;
		clear_sums();
	end

	always @(posedge clk) begin
		longint xa, ya;
		if (arst_n) begin
			if (done)
				compare_result();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FIRST_ON_X: x_first = cfg_data;
					CFG_SECOND_ON_X: x_second = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				// a marker reads missing only when all three bits are set
				if (founder && !(first_bit_one && first_bit_two && first_missing) &&
						!(second_bit_one && second_bit_two && second_missing) &&
						n_acc < MAX_N) begin
					xa = minor_alleles(first_bit_one, first_bit_two, x_first && male);
					ya = minor_alleles(second_bit_one, second_bit_two, x_second && male);
					n_acc++;
					sum_x += xa;
					sum_y += ya;
					sum_xx += xa * xa;
					sum_yy += ya * ya;
					sum_xy += xa * ya;
				end
				if (last) begin
					ld_expected.insert(ld_expected.size(), ld_from_sums(n_acc, sum_x, sum_y,
						sum_xx, sum_yy, sum_xy));
					clear_sums();
				end
			end
			ld_pending = ld_expected.size();
		end
	end

endmodule

// File: dv/tb_top.sv
// Top of the pairwise_ld_r2_dprime testbench: clock, reset, sample and config stimulus.
// Instantiates the block and ld_pair_checker; depends on pldr_pkg.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pldr_pkg::*;

	localparam int MAX_N       = 65536;
	localparam int RANDOM_ITEMS = 1350;
	localparam int PHASE_ITEMS = 225;

	// marker bits packed as {bit_one, bit_two, missing}
	typedef struct packed {
		logic       founder;
		logic       male;
		logic [2:0] first;
		logic [2:0] second;
		logic       last;
	} sample_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	cfg_idx_t           cfg_index;
	logic               cfg_data;
	logic               start;
	logic               busy;
	logic               founder, male;
	logic               first_bit_one, first_bit_two, first_missing;
	logic               second_bit_one, second_bit_two, second_missing;
	logic               last;
	logic               done;
	logic [R2_W-1:0]    r_squared;
	logic               r_squared_valid;
	logic signed [DP_W-1:0] d_prime;
	logic               d_prime_valid;
	logic [NS_OUT_W-1:0] used_samples;
	int                 fail_count;
	int                 ld_pending;
	int                 items_sent;
	logic               no_gaps;

	pairwise_ld_r2_dprime #(.MAX_SAMPLES(MAX_N)) u_top (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.start, .busy, .founder, .male,
		.first_bit_one, .first_bit_two, .first_missing,
		.second_bit_one, .second_bit_two, .second_missing, .last,
		.done, .r_squared, .r_squared_valid, .d_prime, .d_prime_valid, .used_samples
	);

	ld_pair_checker #(.MAX_N(MAX_N)) u_checker (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.start, .busy, .founder, .male,
		.first_bit_one, .first_bit_two, .first_missing,
		.second_bit_one, .second_bit_two, .second_missing, .last,
		.done, .r_squared, .r_squared_valid, .d_prime, .d_prime_valid, .used_samples,
		.fail_count, .ld_pending
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_sample(input sample_t s);
		@(negedge clk);
		start <= 1'b1;
		founder <= s.founder;
		male <= s.male;
		{first_bit_one, first_bit_two, first_missing} <= s.first;
		{second_bit_one, second_bit_two, second_missing} <= s.second;
		last <= s.last;
		do
			@(posedge clk);
		while (busy);
		items_sent++;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic sender_gap();
		int n;
		int pick;
		pick = $urandom_range(0, 99);
		if (no_gaps || pick < 60)
			n = 0;
		else if (pick < 92)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(10, 40);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// hold off until every predicted word is back and the block is idle
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (ld_pending != 0 || busy)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic set_flags(input logic fx, input logic sx);
		drain();
		write_reg(CFG_FIRST_ON_X, fx);
		write_reg(CFG_SECOND_ON_X, sx);
	endtask

	function automatic sample_t mk(logic f, logic m, logic [2:0] p, logic [2:0] q, logic l);
		sample_t s;
		s.founder = f;
		s.male = m;
		s.first = p;
		s.second = q;
		s.last = l;
		return s;
	endfunction

	function automatic logic [2:0] rand_marker();
		if ($urandom_range(0, 9) == 0)
			return 3'b111;
		return 3'($urandom_range(0, 6));
	endfunction

	// flip the allele count: 0 and 2 swap, heterozygous stays
	function automatic logic [2:0] flip_marker(logic [2:0] p);
		if (p == 3'b111)
			return p;
		if (p[2])
			return {2'b00, p[0]};
		if (!p[1])
			return {2'b10, p[0]};
		return p;
	endfunction

	task automatic random_set();
		int      len;
		int      mode;
		sample_t s;
		len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 80);
		mode = $urandom_range(0, 2);
		for (int i = 0; i < len; i++) begin
			s.founder = ($urandom_range(0, 99) < 88);
			s.male = 1'($urandom_range(0, 1));
			s.first = rand_marker();
			if (mode == 0 || $urandom_range(0, 99) < 15)
				s.second = rand_marker();
			else if (mode == 1)
				s.second = s.first;
			else
				s.second = flip_marker(s.first);
			s.last = (i == len - 1);
			send_sample(s);
			sender_gap();
		end
	endtask

	initial begin
		logic [1:0] flags;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FIRST_ON_X;
		cfg_data = 1'b0;
		start = 1'b0;
		{founder, male, first_bit_one, first_bit_two, first_missing} = '0;
		{second_bit_one, second_bit_two, second_missing, last} = '0;
		items_sent = 0;
		no_gaps = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty sets: non-founder, missing at either marker
		send_sample(mk(1'b0, 1'b0, 3'b000, 3'b000, 1'b1));
		send_sample(mk(1'b1, 1'b0, 3'b111, 3'b000, 1'b1));
		send_sample(mk(1'b1, 1'b1, 3'b000, 3'b111, 1'b1));
		// lone sample, zero variance
		send_sample(mk(1'b1, 1'b0, 3'b000, 3'b100, 1'b1));
		// complete association, both signs
		send_sample(mk(1'b1, 1'b0, 3'b100, 3'b100, 1'b0));
		send_sample(mk(1'b1, 1'b1, 3'b000, 3'b000, 1'b1));
		send_sample(mk(1'b1, 1'b0, 3'b100, 3'b000, 1'b0));
		send_sample(mk(1'b1, 1'b0, 3'b000, 3'b100, 1'b1));
		// heterozygotes, missing bit set without the marker being missing
		send_sample(mk(1'b1, 1'b0, 3'b010, 3'b000, 1'b0));
		send_sample(mk(1'b0, 1'b0, 3'b011, 3'b010, 1'b0));
		send_sample(mk(1'b1, 1'b0, 3'b100, 3'b011, 1'b0));
		send_sample(mk(1'b1, 1'b1, 3'b001, 3'b101, 1'b0));
		send_sample(mk(1'b1, 1'b0, 3'b000, 3'b110, 1'b1));

		// both markers on X: males haploid
		set_flags(1'b1, 1'b1);
		send_sample(mk(1'b1, 1'b1, 3'b000, 3'b100, 1'b0));
		send_sample(mk(1'b1, 1'b1, 3'b010, 3'b000, 1'b0));
		send_sample(mk(1'b1, 1'b0, 3'b000, 3'b000, 1'b0));
		send_sample(mk(1'b1, 1'b1, 3'b100, 3'b110, 1'b0));
		send_sample(mk(1'b1, 1'b0, 3'b010, 3'b011, 1'b1));

		for (int ph = 0; items_sent < RANDOM_ITEMS + 18; ph++) begin
			case (ph)
				0: flags = 2'b00;
				1: flags = 2'b11;
				2: flags = 2'b10;
				3: flags = 2'b01;
				default: flags = 2'($urandom_range(0, 3));
			endcase
			set_flags(flags[1], flags[0]);
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int k = items_sent; items_sent < k + PHASE_ITEMS;) begin
				random_set();
				if ($urandom_range(0, 9) == 0)
					drain();
			end
		end

		drain();
		repeat (440) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
